// File: hw/rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication that holds in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// File: hw/rtl/plt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_pkg
// Types and codes shared by the piecewise linear time table.
// ----------------------------------------------------------------------------
package plt_pkg;

  localparam logic       MODE_LOAD  = 1'b0;
  localparam logic       MODE_EVAL  = 1'b1;

  localparam logic [1:0] ORD_VALUE  = 2'd0;
  localparam logic [1:0] ORD_SLOPE  = 2'd1;
  localparam logic [1:0] ORD_SECOND = 2'd2;
  localparam logic [1:0] ORD_BAD    = 2'd3;

  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_BEFORE = 2'd1;
  localparam logic [1:0] ERR_AFTER  = 2'd2;
  localparam logic [1:0] ERR_ORDER  = 2'd3;

  localparam logic [1:0] CFG_POINTS = 2'd0;
  localparam logic [1:0] CFG_PERIOD = 2'd1;
  localparam logic [1:0] CFG_WSTART = 2'd2;
  localparam logic [1:0] CFG_WEND   = 2'd3;

  localparam logic [40:0] QUO_MAX   = 41'h1FFFFFFFFFF;

  typedef struct packed {
    logic              valid;
    logic              found;
    logic signed [31:0] t;
    logic signed [31:0] ta;
    logic signed [31:0] va;
    logic signed [31:0] tb;
    logic signed [31:0] vb;
  } token_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SRCH,
    ST_WAIT,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

// File: hw/rtl/plt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_cell
// One breakpoint slot; a search token passes through it each cycle.
// ----------------------------------------------------------------------------
module plt_cell #(
  parameter int INDEX = 0,
  parameter int NW    = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ld_en,
  input  logic signed [31:0]  ld_time,
  input  logic signed [31:0]  ld_value,
  input  logic [NW-1:0]       n_eff,
  input  logic signed [31:0]  prev_time,
  input  logic signed [31:0]  prev_value,
  input  plt_pkg::token_t     tok_in,
  output plt_pkg::token_t     tok_out,
  output logic signed [31:0]  cell_time,
  output logic signed [31:0]  cell_value
);

  logic signed [31:0] time_r;
  logic signed [31:0] value_r;
  plt_pkg::token_t    tok_r;
  plt_pkg::token_t    tok_nxt;
  logic               active;
  logic               hit;

  assign active = (INDEX != 0) && (NW'(INDEX) < n_eff);
  assign hit    = active && tok_in.valid && !tok_in.found && (time_r >= tok_in.t);

  always_comb begin
    tok_nxt = tok_in;
    if (hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.ta    = prev_time;
      tok_nxt.va    = prev_value;
      tok_nxt.tb    = time_r;
      tok_nxt.vb    = value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_en) begin
      time_r  <= ld_time;
      value_r <= ld_value;
    end
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out    = tok_r;
  assign cell_time  = time_r;
  assign cell_value = value_r;

endmodule

// File: hw/rtl/plt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_div
// Bit-serial restoring divider, 64 by 32 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plt_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [63:0] quo,
  output logic [31:0] rem
);

  logic [63:0] num_r;
  logic [63:0] quo_r;
  logic [31:0] rem_r;
  logic [31:0] den_r;
  logic [6:0]  cnt_r;
  logic        done_r;
  logic [32:0] sh;
  logic        ge;

  assign sh = {rem_r, num_r[63]};
  assign ge = sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 7'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r <= num;
        den_r <= den;
        rem_r <= 32'd0;
        quo_r <= 64'd0;
        cnt_r <= 7'd64;
      end else if (cnt_r != 7'd0) begin
        num_r <= {num_r[62:0], 1'b0};
        rem_r <= ge ? 32'(sh - {1'b0, den_r}) : sh[31:0];
        quo_r <= {quo_r[62:0], ge};
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// File: hw/rtl/piecewise_linear_time_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_time_table
// Breakpoint table with periodic wrap and linear interpolation in Q16.16.
// ----------------------------------------------------------------------------
// A load request is written into its breakpoint cell when it is accepted. A
// query that needs interpolation or a slope runs through the wrap step (when
// the time is wrapped), the search, the multiply and the division before the
// next request can be taken: the search token walks the row of breakpoint
// cells one cell per cycle, and the wrap remainder and the final quotient each
// come from the shared bit-serial divider at one bit per cycle. Queries ending
// in an error, asking for the second derivative or landing on a degenerate
// segment skip the quotient division; a time before the first breakpoint also
// skips the cell walk. A stalled result register holds the query in its final
// state. One query is worked at a time; a finished result waits in the output register while the next request is taken.
module piecewise_linear_time_table #(
  parameter int MAX_POINTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [3:0]         in_point_index,
  input  logic signed [31:0] in_point_time,
  input  logic signed [31:0] in_point_value,
  input  logic signed [31:0] in_query_time,
  input  logic [1:0]         in_derivative_order,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value,
  output logic               out_in_range,
  output logic [1:0]         out_error_code,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW = $clog2(MAX_POINTS + 1);

  logic [4:0]         points_r;
  logic               periodic_r;
  logic signed [31:0] wstart_r;
  logic signed [31:0] wend_r;

  plt_pkg::state_t    state_r, state_nxt;

  logic signed [31:0] t_r;
  logic               tneg_r;
  logic [1:0]         order_r;
  logic               inr_r;
  logic [1:0]         err_r;
  logic signed [31:0] res_r;
  logic               dvneg_r;
  logic [31:0]        dvmag_r;
  logic [31:0]        dx_r;
  logic [31:0]        dt_r;
  logic signed [31:0] va_r;
  logic [63:0]        prod_r;

  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  logic               out_inr_r;
  logic [1:0]         out_err_r;

  logic [NW-1:0]      n_eff;
  logic [IW-1:0]      nm1;
  logic signed [31:0] t0, tl;
  logic signed [32:0] period;
  logic               accept, acc_eval, wrap_go;
  logic [32:0]        qneg;
  logic [31:0]        qmag;
  logic               finish, lt0;

  logic               div_start, div_done;
  logic [63:0]        div_num, div_quo;
  logic [31:0]        div_den, div_rem;

  plt_pkg::token_t    tok [MAX_POINTS+1];
  logic signed [31:0] cell_time  [MAX_POINTS];
  logic signed [31:0] cell_value [MAX_POINTS];
  plt_pkg::token_t    co;

  logic signed [32:0] dt33, dv33, dx33;
  logic               degen;
  logic               rnd;
  logic [63:0]        q1;
  logic [40:0]        qc;
  logic signed [42:0] qs, sum;
  logic signed [31:0] sat;

  // clamp table size
  always_comb begin
    if (points_r < 5'd2) begin
      n_eff = NW'(2);
    end else if (32'(points_r) > MAX_POINTS) begin
      n_eff = NW'(MAX_POINTS);
    end else begin
      n_eff = NW'(points_r);
    end
  end

  assign nm1    = IW'(n_eff - NW'(1));
  assign t0     = cell_time[0];
  assign tl     = cell_time[nm1];
  assign period = {tl[31], tl} - {t0[31], t0};

  assign accept   = in_valid && in_ready;
  assign acc_eval = accept && (in_mode == plt_pkg::MODE_EVAL);
  assign wrap_go  = periodic_r && (in_query_time >= wstart_r) && (in_query_time <= wend_r)
                    && (period > 33'sd0);
  assign qneg     = 33'd0 - {in_query_time[31], in_query_time};
  assign qmag     = in_query_time[31] ? qneg[31:0] : in_query_time;
  assign lt0      = t_r < t0;
  assign finish   = !out_valid_r || out_ready;

  // breakpoint cells
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = (state_r == plt_pkg::ST_SRCH) && !lt0;
    tok[0].t     = t_r;
  end

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    logic signed [31:0] pt, pv;
    if (i == 0) begin : g_first
      assign pt = 32'sd0;
      assign pv = 32'sd0;
    end else begin : g_rest
      assign pt = cell_time[i-1];
      assign pv = cell_value[i-1];
    end
    plt_cell #(.INDEX(i), .NW(NW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ld_en      (accept && (in_mode == plt_pkg::MODE_LOAD)
                   && (32'(in_point_index) == i)),
      .ld_time    (in_point_time),
      .ld_value   (in_point_value),
      .n_eff      (n_eff),
      .prev_time  (pt),
      .prev_value (pv),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1]),
      .cell_time  (cell_time[i]),
      .cell_value (cell_value[i])
    );
  end

  assign co = tok[MAX_POINTS];

  // shared divider
  assign div_start = (acc_eval && wrap_go) || (state_r == plt_pkg::ST_DSTART);
  assign div_num   = (state_r == plt_pkg::ST_IDLE) ? 64'(qmag) : prod_r;
  assign div_den   = (state_r == plt_pkg::ST_IDLE) ? period[31:0] : dt_r;

  plt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // segment terms
  assign dt33  = {co.tb[31], co.tb} - {co.ta[31], co.ta};
  assign dv33  = {co.vb[31], co.vb} - {co.va[31], co.va};
  assign dx33  = {t_r[31], t_r} - {co.ta[31], co.ta};
  assign degen = (dt33 <= 33'sd0) || (dx33 < 33'sd0) || (dx33 > dt33);

  // round, clamp, saturate
  assign rnd = div_rem >= (dt_r - div_rem);
  assign q1  = div_quo + 64'(rnd);
  assign qc  = (q1 > 64'(plt_pkg::QUO_MAX)) ? plt_pkg::QUO_MAX : q1[40:0];
  assign qs  = dvneg_r ? (43'sd0 - $signed({2'b0, qc})) : $signed({2'b0, qc});
  assign sum = (order_r == plt_pkg::ORD_VALUE) ? ({{11{va_r[31]}}, va_r} + qs) : qs;

  always_comb begin
    if (sum > 43'sd2147483647) begin
      sat = 32'sh7FFFFFFF;
    end else if (sum < -43'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = sum[31:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      plt_pkg::ST_IDLE: begin
        if (acc_eval) begin
          state_nxt = wrap_go ? plt_pkg::ST_MOD : plt_pkg::ST_SRCH;
        end
      end
      plt_pkg::ST_MOD: begin
        if (div_done) begin
          state_nxt = plt_pkg::ST_SRCH;
        end
      end
      plt_pkg::ST_SRCH: begin
        state_nxt = lt0 ? plt_pkg::ST_FIN : plt_pkg::ST_WAIT;
      end
      plt_pkg::ST_WAIT: begin
        if (co.valid) begin
          if (!co.found || (order_r == plt_pkg::ORD_BAD)
              || (order_r == plt_pkg::ORD_SECOND) || degen) begin
            state_nxt = plt_pkg::ST_FIN;
          end else begin
            state_nxt = plt_pkg::ST_MUL;
          end
        end
      end
      plt_pkg::ST_MUL:    state_nxt = plt_pkg::ST_DSTART;
      plt_pkg::ST_DSTART: state_nxt = plt_pkg::ST_DIV;
      plt_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = plt_pkg::ST_FIN;
        end
      end
      plt_pkg::ST_FIN: begin
        if (finish) begin
          state_nxt = plt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = plt_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready = 1'b0;
    case (state_r)
      plt_pkg::ST_IDLE: in_ready = 1'b1;
      default:          in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      points_r    <= 5'd2;
      periodic_r  <= 1'b0;
      wstart_r    <= 32'sd0;
      wend_r      <= 32'sd0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          plt_pkg::CFG_POINTS: points_r   <= cfg_data[4:0];
          plt_pkg::CFG_PERIOD: periodic_r <= cfg_data[0];
          plt_pkg::CFG_WSTART: wstart_r   <= cfg_data;
          plt_pkg::CFG_WEND:   wend_r     <= cfg_data;
          default: ;
        endcase
      end

      if ((state_r == plt_pkg::ST_FIN) && finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        plt_pkg::ST_IDLE: begin
          if (acc_eval) begin
            t_r     <= in_query_time;
            tneg_r  <= in_query_time[31];
            order_r <= in_derivative_order;
          end
        end
        plt_pkg::ST_MOD: begin
          if (div_done) begin
            t_r <= tneg_r ? (32'sd0 - div_rem) : div_rem;
          end
        end
        plt_pkg::ST_SRCH: begin
          inr_r <= (t_r >= t0) && (t_r <= tl);
          err_r <= plt_pkg::ERR_BEFORE;
          res_r <= 32'sd0;
        end
        plt_pkg::ST_WAIT: begin
          if (co.valid) begin
            if (!co.found) begin
              err_r <= plt_pkg::ERR_AFTER;
            end else if (order_r == plt_pkg::ORD_BAD) begin
              err_r <= plt_pkg::ERR_ORDER;
            end else begin
              err_r <= plt_pkg::ERR_OK;
            end
            res_r   <= (co.found && degen && (order_r == plt_pkg::ORD_VALUE)) ? co.va
                                                                              : 32'sd0;
            dvneg_r <= dv33 < 33'sd0;
            dvmag_r <= dv33[32] ? 32'(33'd0 - dv33) : dv33[31:0];
            dx_r    <= dx33[31:0];
            dt_r    <= dt33[31:0];
            va_r    <= co.va;
          end
        end
        plt_pkg::ST_MUL: begin
          prod_r <= (order_r == plt_pkg::ORD_VALUE) ? (64'(dvmag_r) * 64'(dx_r))
                                                    : {16'd0, dvmag_r, 16'd0};
        end
        plt_pkg::ST_DIV: begin
          if (div_done) begin
            res_r <= sat;
          end
        end
        plt_pkg::ST_FIN: begin
          if (finish) begin
            out_value_r <= res_r;
            out_inr_r   <= inr_r;
            out_err_r   <= err_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_in_range     = out_inr_r;
  assign out_error_code   = out_err_r;

endmodule

// File: hw/rtl/plt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_checker
// Port-level checks on the result channel of the time table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_result_value,
  input logic               out_in_range,
  input logic [1:0]         out_error_code
);

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
  `ASSERT_CLK(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_result_value), "result changed")
  `ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && (out_error_code != plt_pkg::ERR_OK), out_result_value == 32'sd0, "error result not zero")
  `ASSERT_IMPL(a_before_range, clk, rst_n, out_valid && (out_error_code == plt_pkg::ERR_BEFORE), !out_in_range, "before start flagged in range")

endmodule

bind piecewise_linear_time_table plt_checker u_plt_checker (.*);
